FILE: hw/rtl/slc_pkg.sv
// Shared types and constants of the set-associative LRU cache lookup block.
`default_nettype none
package slc_pkg;
    localparam int WAYS_DEF        = 16;
    localparam int SET_BITS_DEF    = 11;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_W          = 64;
    localparam int THR_W           = 8;
    localparam int CNT_W           = 32;
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 144;

    // One queued access.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [THR_W-1:0]  thread;
    } t_req;
endpackage
`default_nettype wire

FILE: hw/rtl/slc_front.sv
// Front end: accepts accesses and holds them in a two-entry queue for the back end.
`default_nettype none
module slc_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_clr_done,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [slc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  o_req_valid,
    output slc_pkg::t_req                         o_req,
    input  wire logic                             i_req_take
);
    import slc_pkg::*;

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    // Accept only once the tag store is cleared and a slot is free
    assign s_axis_tready = i_clr_done && (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = i_req_take && (r_cnt != 2'd0);
    assign o_req_valid   = (r_cnt != 2'd0);
    assign o_req         = r_q[r_rd_ptr];

    // Store incoming transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr].thread <= s_axis_tdata[THR_W-1:0];
            r_q[r_wr_ptr].addr   <= s_axis_tdata[THR_W+ADDR_W-1:THR_W];
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/slc_back.sv
// Back end: tag store, LRU ranks, hit/miss decision, counters and result register.
`default_nettype none
module slc_back #(
    parameter int WAYS        = slc_pkg::WAYS_DEF,
    parameter int SET_BITS    = slc_pkg::SET_BITS_DEF,
    parameter int OFFSET_BITS = slc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    output logic                                  o_clr_done,
    input  wire logic                             i_req_valid,
    input  wire slc_pkg::t_req                    i_req,
    output logic                                  o_req_take,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [slc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import slc_pkg::*;

    localparam int TW   = ADDR_W - SET_BITS - OFFSET_BITS;
    localparam int RW   = $clog2(WAYS);
    localparam int SETS = 1 << SET_BITS;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_LOOK} t_state;

    // Per-set rows of the tag store
    logic [WAYS-1:0]            mem_valid [SETS];
    logic [WAYS-1:0][RW-1:0]    mem_rank  [SETS];
    logic [WAYS-1:0][TW-1:0]    mem_tag   [SETS];

    t_state                  r_state;
    logic [SET_BITS-1:0]     r_clr_addr;
    t_req                    r_cur;
    logic [WAYS-1:0]         r_valid_rd;
    logic [WAYS-1:0][RW-1:0] r_rank_rd;
    logic [WAYS-1:0][TW-1:0] r_tag_rd;
    logic [CNT_W-1:0]        r_hit_cnt;
    logic [CNT_W-1:0]        r_miss_cnt;
    logic                    r_out_valid;
    logic                    r_out_hit;
    t_req                    r_out_req;

    logic [SET_BITS-1:0]     cur_set;
    logic [TW-1:0]           cur_tag;
    logic [SET_BITS-1:0]     req_set;
    logic [WAYS-1:0]         match;
    logic [WAYS-1:0]         inval;
    logic [WAYS-1:0]         free_oh;
    logic [WAYS-1:0]         victim_oh;
    logic [WAYS-1:0]         sel;
    logic [RW:0]             old_rank;
    logic [WAYS-1:0][RW-1:0] new_rank;
    logic                    hit;
    logic                    load;

    assign req_set    = i_req.addr[OFFSET_BITS+SET_BITS-1:OFFSET_BITS];
    assign cur_set    = r_cur.addr[OFFSET_BITS+SET_BITS-1:OFFSET_BITS];
    assign cur_tag    = r_cur.addr[ADDR_W-1:OFFSET_BITS+SET_BITS];
    assign o_clr_done = (r_state != S_CLR);
    assign o_req_take = (r_state == S_IDLE) && i_req_valid;
    assign load       = (r_state == S_LOOK) && (!r_out_valid || m_axis_tready);

    // Classify the set: hit way, lowest free way, oldest way
    always_comb begin
        old_rank = '0;
        for (int i = 0; i < WAYS; i++) begin
            match[i]     = r_valid_rd[i] && (r_tag_rd[i] == cur_tag);
            victim_oh[i] = (r_rank_rd[i] == RW'(WAYS - 1));
        end
        inval   = ~r_valid_rd;
        free_oh = inval & (~inval + WAYS'(1));
        hit     = |match;
        if (hit)        sel = match;
        else if (|inval) sel = free_oh;
        else            sel = victim_oh;
        if (!hit && (|inval)) begin
            old_rank = (RW+1)'(WAYS);
        end else begin
            for (int i = 0; i < WAYS; i++) begin
                if (sel[i]) old_rank = old_rank | {1'b0, r_rank_rd[i]};
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            if (sel[i])
                new_rank[i] = '0;
            else if (r_valid_rd[i] && ({1'b0, r_rank_rd[i]} < old_rank))
                new_rank[i] = r_rank_rd[i] + RW'(1);
            else
                new_rank[i] = r_rank_rd[i];
        end
    end

    // Read the set row on issue
    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_valid_rd <= mem_valid[req_set];
            r_rank_rd  <= mem_rank[req_set];
            r_tag_rd   <= mem_tag[req_set];
            r_cur      <= i_req;
        end
    end

    // Clear valid rows after reset, write back updated rows
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            mem_valid[r_clr_addr] <= '0;
        end else if (load) begin
            mem_valid[cur_set] <= r_valid_rd | sel;
            mem_rank[cur_set]  <= new_rank;
            for (int i = 0; i < WAYS; i++) begin
                if (sel[i]) mem_tag[cur_set][i] <= cur_tag;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_hit <= hit;
            r_out_req <= r_cur;
        end
    end

    // Sequencer, counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)               r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + SET_BITS'(1);
                    if (r_clr_addr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req_valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (load) begin
                        r_state     <= S_IDLE;
                        if (hit) begin
                            if (r_hit_cnt != '1) r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                        end else begin
                            if (r_miss_cnt != '1) r_miss_cnt <= r_miss_cnt + CNT_W'(1);
                        end
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_miss_cnt, r_hit_cnt, r_out_req.addr,
                            r_out_req.thread, r_out_hit};

    // Valid tags in a set never repeat
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $onehot0(match))
        else $error("duplicate valid tag in set");

    // Exactly one way is chosen for update
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> $onehot(sel))
        else $error("way select not one-hot");

    // A hit bumps the hit count unless saturated
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && hit) |=> (r_hit_cnt != $past(r_hit_cnt)) || (r_hit_cnt == '1))
        else $error("hit count not advanced");

    // No lookup issued and no result valid during the clearing pass
    a_no_take_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_req_take && !r_out_valid)
        else $error("activity during clear");
endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_lookup_top.sv
// Top level of the set-associative LRU cache lookup block.
// An access waits in the front queue, its set row is read into registers, and
// the row is written back as the result register loads; no new access is taken
// before then: the row is read and written back through the store's single port.
// Reset: synchronous active low; then a clearing pass over all 2**SET_BITS sets
// (2048 by default) zeroes the valid bits, with s_axis_tready low until it ends.
`default_nettype none
module set_assoc_lru_cache_lookup_top #(
    parameter int WAYS        = slc_pkg::WAYS_DEF,
    parameter int SET_BITS    = slc_pkg::SET_BITS_DEF,
    parameter int OFFSET_BITS = slc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // thread_id[7:0], address[71:8]
    input  wire logic [slc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // hit[0], thread_echo[8:1], address_echo[72:9], hit_total[104:73],
    // miss_total[136:105], zero fill above
    output logic [slc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import slc_pkg::*;

    logic clr_done;
    logic req_valid;
    logic req_take;
    t_req req;

    slc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr_done    (clr_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_req_take    (req_take)
    );

    slc_back #(
        .WAYS        (WAYS),
        .SET_BITS    (SET_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_clr_done    (clr_done),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_take    (req_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench of the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

module testbench;
    import slc_pkg::*;

    localparam int NWAYS   = 16;
    localparam int NSETS   = 2048;
    localparam int TAG_W   = 47;
    localparam int WDOG    = 6000;
    localparam int NRAND   = 780;
    localparam int NPOOL   = 20;

    typedef struct {
        logic              hit;
        logic [THR_W-1:0]  thread;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } t_lookup;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // thread_id, address
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // hit, thread, address, hits, misses

    // Predicted tag store and counters
    logic [NWAYS-1:0] way_valid [NSETS];
    logic [TAG_W-1:0] way_tag   [NSETS][NWAYS];
    logic [3:0]       way_age   [NSETS][NWAYS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;

    t_req    access_queue[$];
    t_lookup lookup_queue[$];
    logic [TAG_W-1:0] tag_pool [NPOOL];
    logic [10:0]      hot_set  [4];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req;
    int  hold_seen;
    int  hold_left;
    int  errors;
    int  quiet_cycles;

    set_assoc_lru_cache_lookup_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Make a way most recent; younger valid ways age by one
    function automatic void make_recent(int s, int w, int old_age);
        for (int i = 0; i < NWAYS; i++) begin
            if (i != w && way_valid[s][i] && int'(way_age[s][i]) < old_age) begin
                way_age[s][i] = way_age[s][i] + 4'd1;
            end
        end
        way_age[s][w] = 4'd0;
    endfunction

    // Classify one access and update the predicted store
    function automatic t_lookup classify_access(t_req r);
        t_lookup          res;
        int               s;
        int               w;
        logic [TAG_W-1:0] tg;
        logic             found;
        s = int'(r.addr[16:6]);
        tg = r.addr[63:17];
        found = 1'b0;
        w = 0;
        for (int i = 0; i < NWAYS; i++) begin
            if (!found && way_valid[s][i] && way_tag[s][i] == tg) begin
                found = 1'b1;
                w = i;
            end
        end
        if (found) begin
            make_recent(s, w, int'(way_age[s][w]));
            if (hit_count != '1) hit_count++;
        end else begin
            if (way_valid[s] != '1) begin
                for (int i = NWAYS - 1; i >= 0; i--) begin
                    if (!way_valid[s][i]) w = i;
                end
                make_recent(s, w, NWAYS);
                way_valid[s][w] = 1'b1;
            end else begin
                w = 0;
                for (int i = 1; i < NWAYS; i++) begin
                    if (way_age[s][i] > way_age[s][w]) w = i;
                end
                make_recent(s, w, int'(way_age[s][w]));
            end
            way_tag[s][w] = tg;
            if (miss_count != '1) miss_count++;
        end
        res.hit    = found;
        res.thread = r.thread;
        res.addr   = r.addr;
        res.hits   = hit_count;
        res.misses = miss_count;
        return res;
    endfunction

    function automatic t_req make_access(logic [TAG_W-1:0] tg, logic [10:0] s,
                                         logic [5:0] off, logic [7:0] thr);
        t_req r;
        r.addr   = {tg, s, off};
        r.thread = thr;
        return r;
    endfunction

    // Drive accesses from the queue; predict each transfer
    always @(posedge i_clk) begin
        logic accepted;
        accepted = s_axis_tvalid && s_axis_tready;
        if (accepted) begin
            lookup_queue.push_back(classify_access(access_queue.pop_front()));
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !accepted) begin
            s_axis_tvalid <= 1'b1;
        end else if (access_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= access_queue[0];
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Check each result transfer; stall the output at random or for a hold
    always @(posedge i_clk) begin
        t_lookup exp;
        t_lookup got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.hit    = m_axis_tdata[0];
            got.thread = m_axis_tdata[8:1];
            got.addr   = m_axis_tdata[72:9];
            got.hits   = m_axis_tdata[104:73];
            got.misses = m_axis_tdata[136:105];
            if (lookup_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
            end else begin
                exp = lookup_queue.pop_front();
                if (got.hit !== exp.hit) begin
                    errors++;
                    $display("%0t: hit exp %b got %b", $time, exp.hit, got.hit);
                end
                if (got.thread !== exp.thread) begin
                    errors++;
                    $display("%0t: thread exp %h got %h", $time, exp.thread, got.thread);
                end
                if (got.addr !== exp.addr) begin
                    errors++;
                    $display("%0t: address exp %h got %h", $time, exp.addr, got.addr);
                end
                if (got.hits !== exp.hits) begin
                    errors++;
                    $display("%0t: hit_total exp %0d got %0d", $time, exp.hits, got.hits);
                end
                if (got.misses !== exp.misses) begin
                    errors++;
                    $display("%0t: miss_total exp %0d got %0d", $time, exp.misses,
                             got.misses);
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Wait until every expected result has come back
    task automatic drain_results();
        while (access_queue.size() > 0 || lookup_queue.size() > 0) @(negedge i_clk);
    endtask

    task automatic queue_random(int count);
        t_req r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) begin
                r = make_access(tag_pool[$urandom_range(NPOOL - 1)],
                                hot_set[$urandom_range(3)],
                                6'($urandom), 8'($urandom));
            end else begin
                r.addr   = {$urandom, $urandom};
                r.thread = 8'($urandom);
            end
            access_queue.push_back(r);
        end
    endtask

    initial begin
        t_req r;
        errors = 0;
        quiet_cycles = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        hit_count = '0;
        miss_count = '0;
        for (int s = 0; s < NSETS; s++) way_valid[s] = '0;
        send_idle_pct = 17;
        recv_idle_pct = 62;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < NPOOL; k++) tag_pool[k] = TAG_W'({$urandom, $urandom});
        hot_set[0] = 11'd0;
        hot_set[1] = 11'd2047;
        hot_set[2] = 11'd3;
        hot_set[3] = 11'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, hits, filling a set, eviction of the oldest way
        access_queue.push_back(make_access('0, 11'd0, 6'd0, 8'd0));
        access_queue.push_back(make_access('1, 11'h7ff, 6'h3f, 8'hff));
        access_queue.push_back(make_access('0, 11'd0, 6'h3f, 8'h5a));
        access_queue.push_back(make_access('1, 11'd0, 6'd0, 8'ha5));
        for (int k = 0; k < NWAYS; k++) begin
            access_queue.push_back(make_access(TAG_W'(k + 100), 11'd9, 6'(k), 8'(k)));
        end
        access_queue.push_back(make_access(TAG_W'(200), 11'd9, 6'd1, 8'd1));
        access_queue.push_back(make_access(TAG_W'(100), 11'd9, 6'd2, 8'd2));
        access_queue.push_back(make_access(TAG_W'(102), 11'd9, 6'd3, 8'd3));
        drain_results();

        queue_random(NRAND / 3);
        drain_results();

        send_idle_pct = 62;
        recv_idle_pct = 17;
        queue_random(NRAND / 3);
        drain_results();

        // No idling; hold the output early so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1;
        queue_random(NRAND - 2 * (NRAND / 3));
        drain_results();

        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/slc_pkg.sv
hw/rtl/slc_front.sv
hw/rtl/slc_back.sv
hw/rtl/set_assoc_lru_cache_lookup_top.sv
test/testbench.sv
